FILE: rtl/rhc_pkg.sv
package rhc_pkg;

   // quotient bits of each divide and how they are spread over the stages
   localparam int QuotWidth     = 16;
   localparam int StepsPerStage = 2;
   localparam int DivStages     = QuotWidth / StepsPerStage;

   typedef enum logic [1:0] {
      MAX_RED,
      MAX_GREEN,
      MAX_BLUE
   } max_sel_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [15:0] hue;
      logic [15:0] saturation;
      logic [8:0]  lightness_sum;
   } rsp_type;

   // after max / min selection
   typedef struct packed {
      logic [7:0]        mx;
      logic [7:0]        mn;
      max_sel_type       sel;
      logic signed [8:0] diff;
   } front_type;

   // state of both long divisions as it moves down the pipe
   typedef struct packed {
      logic        grey;
      logic [7:0]  sat_rem;
      logic [15:0] sat_word;
      logic [7:0]  den;
      logic [10:0] hue_rem;
      logic [15:0] hue_q;
      logic [10:0] d6;
      logic [8:0]  sum;
   } div_stage_type;

endpackage

FILE: rtl/rgb_to_hsl_convert_top.sv
// RGB to HSL converter: one 8-bit RGB pixel in, hue, saturation and the
// lightness sum (max + min, lightness = sum / 510) out, exact to the floor.
// The block accepts one item every cycle unless the result side stalls;
// the result is registered through a front stage that picks max and min, a
// stage that forms the divide operands, and eight stages of two restoring
// divide steps each, running the saturation and hue quotients side by
// side. A stall on the result side holds the whole pipe, so req_ready
// follows rsp_ready whenever the last stage is full.
module rgb_to_hsl_convert_top
   import rhc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic          advance;
   logic          a_valid_ff;
   front_type     a_ff;
   front_type     a_in;
   logic          v_ff [0:DivStages];
   div_stage_type div_ff [0:DivStages];
   div_stage_type b_in;

   assign advance   = !v_ff[DivStages] || rsp_ready;
   assign req_ready = advance;

   // pick max and min; ties go blue over green over red
   always_comb begin
      a_in = '0;
      if (req_data.blue >= req_data.green && req_data.blue >= req_data.red) begin
         a_in.sel  = MAX_BLUE;
         a_in.mx   = req_data.blue;
         a_in.diff = $signed({1'b0, req_data.red}) - $signed({1'b0, req_data.green});
      end else if (req_data.green >= req_data.red) begin
         a_in.sel  = MAX_GREEN;
         a_in.mx   = req_data.green;
         a_in.diff = $signed({1'b0, req_data.blue}) - $signed({1'b0, req_data.red});
      end else begin
         a_in.sel  = MAX_RED;
         a_in.mx   = req_data.red;
         a_in.diff = $signed({1'b0, req_data.green}) - $signed({1'b0, req_data.blue});
      end
      a_in.mn = req_data.red;
      if (req_data.green < a_in.mn) begin
         a_in.mn = req_data.green;
      end
      if (req_data.blue < a_in.mn) begin
         a_in.mn = req_data.blue;
      end
   end

   // form divide operands
   always_comb begin
      logic [7:0]         d;
      logic [11:0]        kd;
      logic signed [11:0] num6;
      d      = a_ff.mx - a_ff.mn;
      b_in   = '0;
      b_in.sum  = {1'b0, a_ff.mx} + {1'b0, a_ff.mn};
      b_in.grey = (d == 8'd0);
      if (b_in.sum <= 9'd255) begin
         b_in.den = b_in.sum[7:0];
      end else begin
         b_in.den = 8'(9'd510 - b_in.sum);
      end
      b_in.d6 = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
      case (a_ff.sel)
         MAX_BLUE:  kd = {2'b00, d, 2'b00};
         MAX_GREEN: kd = {3'b000, d, 1'b0};
         MAX_RED:   kd = a_ff.diff[8] ? {1'b0, b_in.d6} : 12'd0;
         default:   kd = 12'd0;
      endcase
      num6 = 12'(a_ff.diff) + $signed(kd);
      b_in.hue_rem = num6[10:0];
      b_in.hue_q   = '0;
      // d * 65535 = (d - 1) * 65536 + (65536 - d) for nonzero d
      b_in.sat_rem  = d - 8'd1;
      b_in.sat_word = 16'd0 - {8'd0, d};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         v_ff[0]    <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
         v_ff[0]    <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff      <= a_in;
         div_ff[0] <= b_in;
      end
   end

   for (genvar s = 0; s < DivStages; s++) begin : g_div
      div_stage_type div_in;

      always_comb begin
         logic [8:0]  st;
         logic [11:0] ht;
         logic        qb;
         div_in = div_ff[s];
         for (int k = 0; k < StepsPerStage; k++) begin
            // saturation: shift in the next numerator bit
            st = {div_in.sat_rem, div_in.sat_word[15]};
            qb = (st >= {1'b0, div_in.den});
            if (qb) begin
               div_in.sat_rem = 8'(st - {1'b0, div_in.den});
            end else begin
               div_in.sat_rem = st[7:0];
            end
            div_in.sat_word = {div_in.sat_word[14:0], qb};
            // hue: numerator low bits are all zero
            ht = {div_in.hue_rem, 1'b0};
            qb = (ht >= {1'b0, div_in.d6});
            if (qb) begin
               div_in.hue_rem = 11'(ht - {1'b0, div_in.d6});
            end else begin
               div_in.hue_rem = ht[10:0];
            end
            div_in.hue_q = {div_in.hue_q[14:0], qb};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (advance) begin
            v_ff[s+1] <= v_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[s+1] <= div_in;
         end
      end
   end

   // grey pixels carry no hue or saturation
   assign rsp_valid               = v_ff[DivStages];
   assign rsp_data.hue            = div_ff[DivStages].grey ? 16'd0 : div_ff[DivStages].hue_q;
   assign rsp_data.saturation     = div_ff[DivStages].grey ? 16'd0
                                                           : div_ff[DivStages].sat_word;
   assign rsp_data.lightness_sum  = div_ff[DivStages].sum;

endmodule

FILE: dv/rgb_to_hsl_convert_top_tb.sv
`timescale 1ns / 1ps

module rgb_to_hsl_convert_top_tb
   import rhc_pkg::*;
();

   localparam int RandomPixels = 1950;
   localparam int PipeDrain    = 40;

   typedef struct packed {
      req_type px;
      logic    typed;   // want holds a hand-worked result
      rsp_type want;
   } hsl_case_type;

   localparam int NumCases = 24;

   // channel order in each pixel: red, green, blue
   localparam hsl_case_type HslCases [NumCases] = '{
      '{'{8'd0,   8'd0,   8'd0  }, 1'b1, '{16'd0,     16'd0,     9'd0  }},
      '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{16'd0,     16'd0,     9'd510}},
      '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{16'd0,     16'd0,     9'd256}},
      '{'{8'd1,   8'd1,   8'd1  }, 1'b1, '{16'd0,     16'd0,     9'd2  }},
      '{'{8'd254, 8'd254, 8'd254}, 1'b1, '{16'd0,     16'd0,     9'd508}},
      '{'{8'd255, 8'd0,   8'd0  }, 1'b1, '{16'd0,     16'd65535, 9'd255}},
      '{'{8'd0,   8'd255, 8'd0  }, 1'b1, '{16'd21845, 16'd65535, 9'd255}},
      '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{16'd43690, 16'd65535, 9'd255}},
      '{'{8'd255, 8'd255, 8'd0  }, 1'b1, '{16'd10922, 16'd65535, 9'd255}},
      '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{16'd32768, 16'd65535, 9'd255}},
      '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{16'd54613, 16'd65535, 9'd255}},
      '{'{8'd255, 8'd0,   8'd1  }, 1'b0, '0},
      '{'{8'd1,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{8'd0,   8'd1,   8'd0  }, 1'b0, '0},
      '{'{8'd0,   8'd0,   8'd1  }, 1'b0, '0},
      '{'{8'd255, 8'd254, 8'd254}, 1'b0, '0},
      '{'{8'd254, 8'd255, 8'd255}, 1'b0, '0},
      '{'{8'd128, 8'd127, 8'd127}, 1'b0, '0},
      '{'{8'd128, 8'd128, 8'd127}, 1'b0, '0},
      '{'{8'd129, 8'd127, 8'd127}, 1'b0, '0},
      '{'{8'd170, 8'd85,  8'd170}, 1'b0, '0},
      '{'{8'd85,  8'd170, 8'd85 }, 1'b0, '0},
      '{'{8'd200, 8'd100, 8'd150}, 1'b0, '0},
      '{'{8'd10,  8'd200, 8'd240}, 1'b0, '0}
   };

   localparam logic [7:0] PixelCorners [4] = '{8'd0, 8'd1, 8'd254, 8'd255};

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rsp_type req_hsl_want;          // result owed by the item on req_data
   rsp_type hsl_expect_q [$];
   int      mismatch_count = 0;
   bit      req_gaps_on = 1'b1;

   rgb_to_hsl_convert_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("rgb_to_hsl_convert_top_tb: errors");
      $finish;
   end

   // exact floor of hue, saturation and max + min for one pixel
   function automatic rsp_type hsl_of_pixel(req_type px);
      logic [63:0] r, g, b, hi, lo, d, sum, den, num6, quot;
      rsp_type res;
      r = 64'(px.red);
      g = 64'(px.green);
      b = 64'(px.blue);
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      d = hi - lo;
      sum = hi + lo;
      res = '0;
      res.lightness_sum = sum[8:0];
      if (d != 0) begin
         den = (sum <= 255) ? sum : 510 - sum;
         quot = (d * 65535) / den;
         res.saturation = quot[15:0];
         // blue beats green beats red when the max is shared
         if (hi == b) begin
            num6 = r + 4 * d - g;
         end else if (hi == g) begin
            num6 = b + 2 * d - r;
         end else if (g < b) begin
            num6 = g + 6 * d - b;
         end else begin
            num6 = g - b;
         end
         quot = (num6 * 65536) / (6 * d);
         res.hue = quot[15:0];
      end
      return res;
   endfunction

   function automatic req_type rand_pixel();
      int         kind, v, w, j, c;
      logic [7:0] ch [3];
      logic [7:0] t;
      req_type    px;
      kind = $urandom_range(0, 9);
      case (kind)
         4: begin
            v = $urandom_range(0, 255);
            foreach (ch[i]) ch[i] = 8'(v);
         end
         5: begin
            v = $urandom_range(0, 255);
            w = $urandom_range(0, 255);
            ch[0] = 8'(v);
            ch[1] = 8'(v);
            ch[2] = 8'(w);
         end
         6: begin
            foreach (ch[i]) ch[i] = PixelCorners[$urandom_range(0, 3)];
         end
         7: begin
            // near grey: small d, saturation divisor sweeps its range
            v = $urandom_range(0, 255);
            foreach (ch[i]) begin
               c = v + int'($urandom_range(0, 4)) - 2;
               if (c < 0) c = 0;
               if (c > 255) c = 255;
               ch[i] = 8'(c);
            end
         end
         8: begin
            // max + min around 255, where the saturation divisor switches
            v = $urandom_range(128, 255);
            w = 255 - v + int'($urandom_range(0, 2)) - 1;
            if (w < 0) w = 0;
            ch[0] = 8'(v);
            ch[1] = 8'(w);
            ch[2] = 8'($urandom_range(w, v));
         end
         default: begin
            foreach (ch[i]) ch[i] = 8'($urandom_range(0, 255));
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         j = $urandom_range(0, 2);
         t = ch[i];
         ch[i] = ch[j];
         ch[j] = t;
      end
      px.red = ch[0];
      px.green = ch[1];
      px.blue = ch[2];
      return px;
   endfunction

   task automatic send_pixel(input req_type px, input rsp_type want);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      req_hsl_want <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // queue owed results on input handshakes, retire them on output handshakes
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) hsl_expect_q.push_back(req_hsl_want);
         if (rsp_valid && rsp_ready) begin
            if (hsl_expect_q.size() == 0) begin
               $error("unexpected item: hue %0d saturation %0d lightness_sum %0d",
                      rsp_data.hue, rsp_data.saturation, rsp_data.lightness_sum);
               mismatch_count++;
            end else begin
               want = hsl_expect_q.pop_front();
               if (rsp_data.hue !== want.hue) begin
                  $error("hue: expected %0d, got %0d", want.hue, rsp_data.hue);
                  mismatch_count++;
               end
               if (rsp_data.saturation !== want.saturation) begin
                  $error("saturation: expected %0d, got %0d",
                         want.saturation, rsp_data.saturation);
                  mismatch_count++;
               end
               if (rsp_data.lightness_sum !== want.lightness_sum) begin
                  $error("lightness_sum: expected %0d, got %0d",
                         want.lightness_sum, rsp_data.lightness_sum);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // result side: random stalls before each item, switched on or off at random for each run of 64 items
   initial begin
      int  stall;
      int  taken;
      bit  stalls_on;
      rsp_ready <= 1'b0;
      taken = 0;
      stalls_on = 1'b1;
      @(negedge reset);
      forever begin
         if (taken % 64 == 0) stalls_on = ($urandom_range(0, 3) != 0);
         stall = stalls_on ? $urandom_range(0, 14) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin
      req_type px;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      req_hsl_want <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NumCases; i++) begin
         send_pixel(HslCases[i].px,
                    HslCases[i].typed ? HslCases[i].want : hsl_of_pixel(HslCases[i].px));
      end

      for (int i = 0; i < RandomPixels; i++) begin
         if (i % 64 == 0) req_gaps_on = ($urandom_range(0, 3) != 0);
         px = rand_pixel();
         send_pixel(px, hsl_of_pixel(px));
      end
      req_valid <= 1'b0;

      // drain, then hold a while to catch stray items
      while (hsl_expect_q.size() != 0) @(posedge clock);
      repeat (PipeDrain) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("rgb_to_hsl_convert_top_tb: clean");
      end else begin
         $display("rgb_to_hsl_convert_top_tb: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/rhc_pkg.sv
rtl/rgb_to_hsl_convert_top.sv
dv/rgb_to_hsl_convert_top_tb.sv
